### rtl/rbw_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helpers for the Breit-Wigner lineshape pipeline.
package rbw_pkg;

    localparam int FRAC_BITS_DEFAULT = 24;

    localparam logic [63:0] ONE_Q    = 64'h0000_0001_0000_0000;
    localparam logic [63:0] ALL_ONES = {64{1'b1}};

    localparam logic [63:0] DIVISOR_THREE = 64'd3;
    localparam logic [63:0] DIVISOR_NINE  = 64'd9;

    // Reciprocals for division by three and by nine: the high half of the
    // 128-bit product, shifted right, is the exact truncated quotient.
    localparam logic [63:0] DIV3_MAGIC = 64'hAAAA_AAAA_AAAA_AAAB;
    localparam int          DIV3_SHIFT = 1;
    localparam logic [63:0] DIV9_MAGIC = 64'hE38E_38E3_8E38_E38F;
    localparam int          DIV9_SHIFT = 3;

    localparam int MUL_LAT = 2;

    localparam int DIV_BITS_PER_STAGE = 4;
    localparam int DIV_STAGES         = 64 / DIV_BITS_PER_STAGE;
    localparam int DIV_LAT            = DIV_STAGES + 1;

    localparam int SQRT_BITS_PER_STAGE = 4;
    localparam int SQRT_STAGES         = 48 / SQRT_BITS_PER_STAGE;
    localparam int SQRT_LAT            = SQRT_STAGES + 1;

    localparam logic [31:0] RESET_POLE_MASS      = 32'd16777216;
    localparam logic [31:0] RESET_POLE_WIDTH     = 32'd16777216;
    localparam logic [31:0] RESET_DAUGHTER_A     = 32'd16777216;
    localparam logic [31:0] RESET_DAUGHTER_B     = 32'd16777216;
    localparam logic [31:0] RESET_BARRIER_RADIUS = 32'd50331648;

    typedef enum logic [2:0] {
        REG_POLE_MASS       = 3'd0,
        REG_POLE_WIDTH      = 3'd1,
        REG_DAUGHTER_MASS_A = 3'd2,
        REG_DAUGHTER_MASS_B = 3'd3,
        REG_BARRIER_RADIUS  = 3'd4,
        REG_ORBITAL_WAVE    = 3'd5,
        REG_TWO_BODY_MODE   = 3'd6
    } cfg_reg_t;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? ALL_ONES : s[63:0];
    endfunction

endpackage

### rtl/relativistic_breit_wigner_lineshape.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle while the pipeline is not frozen; every multiplier, divider
// and root unit is fully pipelined.
// The pipeline freezes only when the output register holds a word that is not taken
// and the last stage holds the next word.
// Reset is synchronous and active low; it clears the valid bits and loads register defaults.
module relativistic_breit_wigner_lineshape #(
    parameter int FRAC_BITS = rbw_pkg::FRAC_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // mass_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // shape_value
    output logic [1:0]  m_tuser,   // saturated_flag (bit 1), invalid_flag (bit 0)
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    localparam int SH    = 32 - FRAC_BITS;
    localparam int LM    = rbw_pkg::MUL_LAT;
    localparam int LD    = rbw_pkg::DIV_LAT;
    localparam int LS    = rbw_pkg::SQRT_LAT;
    localparam int TOTAL = 14 * LM + 3 * LD + 2 * LS;

    logic [31:0] pole_mass_reg, pole_width_reg, daughter_a_reg, daughter_b_reg;
    logic [31:0] barrier_radius_reg;
    logic [1:0]  orbital_wave_reg;
    logic        two_body_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pole_mass_reg      <= rbw_pkg::RESET_POLE_MASS;
            pole_width_reg     <= rbw_pkg::RESET_POLE_WIDTH;
            daughter_a_reg     <= rbw_pkg::RESET_DAUGHTER_A;
            daughter_b_reg     <= rbw_pkg::RESET_DAUGHTER_B;
            barrier_radius_reg <= rbw_pkg::RESET_BARRIER_RADIUS;
            orbital_wave_reg   <= 2'd0;
            two_body_mode_reg  <= 1'b0;
        end else if (cfg_we) begin
            case (rbw_pkg::cfg_reg_t'(cfg_index))
                rbw_pkg::REG_POLE_MASS:       pole_mass_reg      <= cfg_wdata;
                rbw_pkg::REG_POLE_WIDTH:      pole_width_reg     <= cfg_wdata;
                rbw_pkg::REG_DAUGHTER_MASS_A: daughter_a_reg     <= cfg_wdata;
                rbw_pkg::REG_DAUGHTER_MASS_B: daughter_b_reg     <= cfg_wdata;
                rbw_pkg::REG_BARRIER_RADIUS:  barrier_radius_reg <= cfg_wdata;
                rbw_pkg::REG_ORBITAL_WAVE:    orbital_wave_reg   <= cfg_wdata[1:0];
                rbw_pkg::REG_TWO_BODY_MODE:   two_body_mode_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    logic en, out_load, in_fire;
    logic out_valid_reg;
    logic [TOTAL-1:0] valid_pipe_reg;

    assign out_load = !out_valid_reg || m_tready;
    assign en       = out_load || !valid_pipe_reg[TOTAL-1];
    assign s_tready = en;
    assign in_fire  = s_tvalid && en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_pipe_reg <= '0;
        end else if (en) begin
            valid_pipe_reg <= {valid_pipe_reg[TOTAL-2:0], in_fire};
        end
    end

    logic [63:0] x_in, m_w, w_w, a_w, b_w, r_w, sum_ab, diff_ab, m_dbl;
    logic [1:0]  l_eff;
    logic        l_is0, l_is1, mode, inv0;

    assign x_in    = 64'(s_tdata) << SH;
    assign m_w     = 64'(pole_mass_reg) << SH;
    assign w_w     = 64'(pole_width_reg) << SH;
    assign a_w     = 64'(daughter_a_reg) << SH;
    assign b_w     = 64'(daughter_b_reg) << SH;
    assign r_w     = 64'(barrier_radius_reg) << SH;
    assign sum_ab  = a_w + b_w;
    assign diff_ab = (a_w > b_w) ? a_w - b_w : b_w - a_w;
    assign m_dbl   = m_w << 1;
    assign mode    = two_body_mode_reg;
    assign l_eff   = (orbital_wave_reg == 2'd3) ? 2'd2 : orbital_wave_reg;
    assign l_is0   = (l_eff == 2'd0);
    assign l_is1   = (l_eff == 2'd1);
    assign inv0    = (x_in == 64'd0) || (m_w == 64'd0)
                   || (mode && ((x_in < sum_ab) || (m_w < sum_ab)));

    // Breakup momentum: squares, then roots, then product over twice the mass.
    logic [63:0] p1_s2, p1_d2, p1_x2, p1_m2, x_p1;
    logic        inv_p1;
    logic [63:0] t1x, t2x, t1m, t2m, diff1;

    rbw_qmul u_mul_s2 (.aclk, .en, .a(sum_ab),  .b(sum_ab),  .p(p1_s2));
    rbw_qmul u_mul_d2 (.aclk, .en, .a(diff_ab), .b(diff_ab), .p(p1_d2));
    rbw_qmul u_mul_x2 (.aclk, .en, .a(x_in),    .b(x_in),    .p(p1_x2));
    rbw_qmul u_mul_m2 (.aclk, .en, .a(m_w),     .b(m_w),     .p(p1_m2));
    rbw_delay #(.WIDTH(65), .DEPTH(LM)) u_dl1 (
        .aclk, .en, .din({x_in, inv0}), .dout({x_p1, inv_p1}));

    assign t1x   = (p1_x2 > p1_s2) ? p1_x2 - p1_s2 : 64'd0;
    assign t2x   = (p1_x2 > p1_d2) ? p1_x2 - p1_d2 : 64'd0;
    assign t1m   = (p1_m2 > p1_s2) ? p1_m2 - p1_s2 : 64'd0;
    assign t2m   = (p1_m2 > p1_d2) ? p1_m2 - p1_d2 : 64'd0;
    assign diff1 = (p1_x2 > p1_m2) ? p1_x2 - p1_m2 : p1_m2 - p1_x2;

    logic [63:0] sq1x, sq2x, sq1m, sq2m, x_p2, diff_p2;
    logic        inv_p2;

    rbw_sqrt u_sqrt_1x (.aclk, .en, .a(t1x), .r(sq1x));
    rbw_sqrt u_sqrt_2x (.aclk, .en, .a(t2x), .r(sq2x));
    rbw_sqrt u_sqrt_1m (.aclk, .en, .a(t1m), .r(sq1m));
    rbw_sqrt u_sqrt_2m (.aclk, .en, .a(t2m), .r(sq2m));
    rbw_delay #(.WIDTH(129), .DEPTH(LS)) u_dl2 (
        .aclk, .en, .din({x_p1, inv_p1, diff1}), .dout({x_p2, inv_p2, diff_p2}));

    logic [63:0] px, pm, x_p3, diff_p3;
    logic        inv_p3;

    rbw_qmul u_mul_px (.aclk, .en, .a(sq1x), .b(sq2x), .p(px));
    rbw_qmul u_mul_pm (.aclk, .en, .a(sq1m), .b(sq2m), .p(pm));
    rbw_delay #(.WIDTH(129), .DEPTH(LM)) u_dl3 (
        .aclk, .en, .din({x_p2, inv_p2, diff_p2}), .dout({x_p3, inv_p3, diff_p3}));

    logic [63:0] qbx, qbm, x_p4, diff_p4, qx_p4, qm_p4;
    logic        inv_p4, inv_q;

    rbw_div u_div_qx (.aclk, .en, .hi(px >> 32), .lo(px << 32), .d(x_p3 << 1),
                      .q(qbx), .sat());
    rbw_div u_div_qm (.aclk, .en, .hi(pm >> 32), .lo(pm << 32), .d(m_dbl),
                      .q(qbm), .sat());
    rbw_delay #(.WIDTH(129), .DEPTH(LD)) u_dl4 (
        .aclk, .en, .din({x_p3, inv_p3, diff_p3}), .dout({x_p4, inv_p4, diff_p4}));

    assign qx_p4 = mode ? qbx : rbw_pkg::ONE_Q;
    assign qm_p4 = mode ? qbm : rbw_pkg::ONE_Q;
    assign inv_q = inv_p4 || (mode && (qbm == 64'd0));

    // Barrier polynomials for the sample and the pole.
    logic [63:0] zx, zm, wm, x_p5, diff_p5, qx_p5, qm_p5;
    logic        inv_p5;

    rbw_qmul u_mul_zx (.aclk, .en, .a(r_w), .b(qx_p4), .p(zx));
    rbw_qmul u_mul_zm (.aclk, .en, .a(r_w), .b(qm_p4), .p(zm));
    rbw_qmul u_mul_wm (.aclk, .en, .a(w_w), .b(m_w),   .p(wm));
    rbw_delay #(.WIDTH(257), .DEPTH(LM)) u_dl5 (
        .aclk, .en,
        .din ({x_p4, inv_q,  diff_p4, qx_p4, qm_p4}),
        .dout({x_p5, inv_p5, diff_p5, qx_p5, qm_p5}));

    logic [63:0] z2x, z2m, x_p6, diff_p6, qx_p6, qm_p6, wm_p6;
    logic        inv_p6;

    rbw_qmul u_mul_z2x (.aclk, .en, .a(zx), .b(zx), .p(z2x));
    rbw_qmul u_mul_z2m (.aclk, .en, .a(zm), .b(zm), .p(z2m));
    rbw_delay #(.WIDTH(321), .DEPTH(LM)) u_dl6 (
        .aclk, .en,
        .din ({x_p5, inv_p5, diff_p5, qx_p5, qm_p5, wm}),
        .dout({x_p6, inv_p6, diff_p6, qx_p6, qm_p6, wm_p6}));

    logic [63:0] z4x, z4m, x_p7, diff_p7, qx_p7, qm_p7, wm_p7, z2x_p7, z2m_p7;
    logic        inv_p7;

    rbw_qmul u_mul_z4x (.aclk, .en, .a(z2x), .b(z2x), .p(z4x));
    rbw_qmul u_mul_z4m (.aclk, .en, .a(z2m), .b(z2m), .p(z4m));
    rbw_delay #(.WIDTH(449), .DEPTH(LM)) u_dl7 (
        .aclk, .en,
        .din ({x_p6, inv_p6, diff_p6, qx_p6, qm_p6, wm_p6, z2x, z2m}),
        .dout({x_p7, inv_p7, diff_p7, qx_p7, qm_p7, wm_p7, z2x_p7, z2m_p7}));

    logic [63:0] z2x3, z2m3, z4x9, z4m9;
    logic [63:0] x_p8, diff_p8, qx_p8, qm_p8, wm_p8, z2x_p8, z2m_p8, dx, dm;
    logic        inv_p8;

    rbw_cdiv #(.MAGIC(rbw_pkg::DIV3_MAGIC), .SHIFT(rbw_pkg::DIV3_SHIFT)) u_div_z2x (
        .aclk, .en, .a(z2x_p7), .q(z2x3));
    rbw_cdiv #(.MAGIC(rbw_pkg::DIV3_MAGIC), .SHIFT(rbw_pkg::DIV3_SHIFT)) u_div_z2m (
        .aclk, .en, .a(z2m_p7), .q(z2m3));
    rbw_cdiv #(.MAGIC(rbw_pkg::DIV9_MAGIC), .SHIFT(rbw_pkg::DIV9_SHIFT)) u_div_z4x (
        .aclk, .en, .a(z4x), .q(z4x9));
    rbw_cdiv #(.MAGIC(rbw_pkg::DIV9_MAGIC), .SHIFT(rbw_pkg::DIV9_SHIFT)) u_div_z4m (
        .aclk, .en, .a(z4m), .q(z4m9));
    rbw_delay #(.WIDTH(449), .DEPTH(LM)) u_dl8 (
        .aclk, .en,
        .din ({x_p7, inv_p7, diff_p7, qx_p7, qm_p7, wm_p7, z2x_p7, z2m_p7}),
        .dout({x_p8, inv_p8, diff_p8, qx_p8, qm_p8, wm_p8, z2x_p8, z2m_p8}));

    assign dx = l_is0 ? rbw_pkg::ONE_Q :
                l_is1 ? rbw_pkg::sat_add(rbw_pkg::ONE_Q, z2x_p8) :
                rbw_pkg::sat_add(rbw_pkg::sat_add(rbw_pkg::ONE_Q, z2x3), z4x9);
    assign dm = l_is0 ? rbw_pkg::ONE_Q :
                l_is1 ? rbw_pkg::sat_add(rbw_pkg::ONE_Q, z2m_p8) :
                rbw_pkg::sat_add(rbw_pkg::sat_add(rbw_pkg::ONE_Q, z2m3), z4m9);

    logic [63:0] r2, gdiv, ratio, diff_p9, qx_p9;
    logic        inv_p9;

    rbw_div u_div_r2 (.aclk, .en, .hi(dm >> 32), .lo(dm << 32), .d(dx),
                      .q(r2), .sat());
    rbw_div u_div_g (.aclk, .en, .hi(wm_p8 >> 32), .lo(wm_p8 << 32), .d(x_p8),
                     .q(gdiv), .sat());
    rbw_div u_div_ratio (.aclk, .en, .hi(qx_p8 >> 32), .lo(qx_p8 << 32), .d(qm_p8),
                         .q(ratio), .sat());
    rbw_delay #(.WIDTH(129), .DEPTH(LD)) u_dl9 (
        .aclk, .en, .din({inv_p8, diff_p8, qx_p8}), .dout({inv_p9, diff_p9, qx_p9}));

    logic [63:0] r1, diff_p10, qx_p10, r2_p10, gdiv_p10, ratio_p10;
    logic        inv_p10;

    rbw_sqrt u_sqrt_r1 (.aclk, .en, .a(r2), .r(r1));
    rbw_delay #(.WIDTH(321), .DEPTH(LS)) u_dl10 (
        .aclk, .en,
        .din ({inv_p9,  diff_p9,  qx_p9,  r2,     gdiv,     ratio}),
        .dout({inv_p10, diff_p10, qx_p10, r2_p10, gdiv_p10, ratio_p10}));

    // Powers of the momentum ratio and of the sample momentum.
    logic [63:0] ra2, qx2, diff_p11, qx_p11, r2_p11, gdiv_p11, ratio_p11, r1_p11;
    logic        inv_p11;

    rbw_qmul u_mul_ra2 (.aclk, .en, .a(ratio_p10), .b(ratio_p10), .p(ra2));
    rbw_qmul u_mul_qx2 (.aclk, .en, .a(qx_p10),    .b(qx_p10),    .p(qx2));
    rbw_delay #(.WIDTH(385), .DEPTH(LM)) u_dl11 (
        .aclk, .en,
        .din ({inv_p10, diff_p10, qx_p10, r2_p10, gdiv_p10, ratio_p10, r1}),
        .dout({inv_p11, diff_p11, qx_p11, r2_p11, gdiv_p11, ratio_p11, r1_p11}));

    logic [63:0] ra3, qx3, diff_p12, qx_p12, r2_p12, gdiv_p12, ratio_p12, r1_p12, qx2_p12;
    logic        inv_p12;

    rbw_qmul u_mul_ra3 (.aclk, .en, .a(ra2), .b(ratio_p11), .p(ra3));
    rbw_qmul u_mul_qx3 (.aclk, .en, .a(qx2), .b(qx_p11),    .p(qx3));
    rbw_delay #(.WIDTH(449), .DEPTH(LM)) u_dl12 (
        .aclk, .en,
        .din ({inv_p11, diff_p11, qx_p11, r2_p11, gdiv_p11, ratio_p11, r1_p11, qx2}),
        .dout({inv_p12, diff_p12, qx_p12, r2_p12, gdiv_p12, ratio_p12, r1_p12, qx2_p12}));

    logic [63:0] ra4, qx4, diff_p13, r2_p13, gdiv_p13, ratio_p13, r1_p13, qx2_p13, ra3_p13;
    logic [63:0] xp;
    logic        inv_p13;

    rbw_qmul u_mul_ra4 (.aclk, .en, .a(ra3), .b(ratio_p12), .p(ra4));
    rbw_qmul u_mul_qx4 (.aclk, .en, .a(qx3), .b(qx_p12),    .p(qx4));
    rbw_delay #(.WIDTH(449), .DEPTH(LM)) u_dl13 (
        .aclk, .en,
        .din ({inv_p12, diff_p12, r2_p12, gdiv_p12, ratio_p12, r1_p12, qx2_p12, ra3}),
        .dout({inv_p13, diff_p13, r2_p13, gdiv_p13, ratio_p13, r1_p13, qx2_p13, ra3_p13}));

    assign xp = l_is0 ? rbw_pkg::ONE_Q : (l_is1 ? qx2_p13 : qx4);

    logic [63:0] ra5, num, diff_p14, gdiv_p14, r1_p14, ratio_p14, ra3_p14, rp;
    logic        inv_p14;

    rbw_qmul u_mul_ra5 (.aclk, .en, .a(ra4), .b(ratio_p13), .p(ra5));
    rbw_qmul u_mul_num (.aclk, .en, .a(xp),  .b(r2_p13),    .p(num));
    rbw_delay #(.WIDTH(321), .DEPTH(LM)) u_dl14 (
        .aclk, .en,
        .din ({inv_p13, diff_p13, gdiv_p13, r1_p13, ratio_p13, ra3_p13}),
        .dout({inv_p14, diff_p14, gdiv_p14, r1_p14, ratio_p14, ra3_p14}));

    assign rp = l_is0 ? ratio_p14 : (l_is1 ? ra3_p14 : ra5);

    // Running width, denominator and final quotient.
    logic [63:0] g1, diff_p15, r1_p15, num_p15;
    logic        inv_p15;

    rbw_qmul u_mul_g1 (.aclk, .en, .a(gdiv_p14), .b(rp), .p(g1));
    rbw_delay #(.WIDTH(193), .DEPTH(LM)) u_dl15 (
        .aclk, .en,
        .din ({inv_p14, diff_p14, r1_p14, num}),
        .dout({inv_p15, diff_p15, r1_p15, num_p15}));

    logic [63:0] gam, diff_p16, num_p16;
    logic        inv_p16;

    rbw_qmul u_mul_gam (.aclk, .en, .a(g1), .b(r1_p15), .p(gam));
    rbw_delay #(.WIDTH(129), .DEPTH(LM)) u_dl16 (
        .aclk, .en,
        .din ({inv_p15, diff_p15, num_p15}),
        .dout({inv_p16, diff_p16, num_p16}));

    logic [63:0] g, dd, num_p17;
    logic        inv_p17;

    rbw_qmul u_mul_g  (.aclk, .en, .a(m_w),      .b(gam),      .p(g));
    rbw_qmul u_mul_dd (.aclk, .en, .a(diff_p16), .b(diff_p16), .p(dd));
    rbw_delay #(.WIDTH(65), .DEPTH(LM)) u_dl17 (
        .aclk, .en, .din({inv_p16, num_p16}), .dout({inv_p17, num_p17}));

    logic [63:0] gg, num_p18, dd_p18, den;
    logic        inv_p18, den_zero;

    rbw_qmul u_mul_gg (.aclk, .en, .a(g), .b(g), .p(gg));
    rbw_delay #(.WIDTH(129), .DEPTH(LM)) u_dl18 (
        .aclk, .en, .din({inv_p17, num_p17, dd}), .dout({inv_p18, num_p18, dd_p18}));

    assign den      = rbw_pkg::sat_add(dd_p18, gg);
    assign den_zero = (den == 64'd0);

    logic [63:0] fq;
    logic        fsat, inv_p19, dz_p19;

    rbw_div u_div_final (.aclk, .en, .hi(num_p18 >> 24), .lo(num_p18 << 40), .d(den),
                         .q(fq), .sat(fsat));
    rbw_delay #(.WIDTH(2), .DEPTH(LD)) u_dl19 (
        .aclk, .en, .din({inv_p18, den_zero}), .dout({inv_p19, dz_p19}));

    logic [63:0] shape_reg, shape_next;
    logic        inv_flag_reg, sat_flag_reg, sat_flag_next, zero_out;

    assign zero_out      = inv_p19 || dz_p19;
    assign shape_next    = zero_out ? 64'd0 : fq;
    assign sat_flag_next = !zero_out && fsat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= valid_pipe_reg[TOTAL-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            shape_reg    <= shape_next;
            inv_flag_reg <= inv_p19;
            sat_flag_reg <= sat_flag_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = shape_reg;
    assign m_tuser  = {sat_flag_reg, inv_flag_reg};

`ifndef SYNTH
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_pipe_reg[TOTAL-1] && out_valid_reg && !m_tready |-> !s_tready)
        else $error("pipeline advanced while its last word could not move");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata == 64'd0) && !m_tuser[1])
        else $error("invalid word carries a nonzero value or saturation");

    a_sat_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> (m_tdata == rbw_pkg::ALL_ONES))
        else $error("saturated word is not at full scale");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        en && valid_pipe_reg[TOTAL-1] |=> out_valid_reg)
        else $error("word at the pipeline end was lost");
`endif

endmodule

### rtl/rbw_qmul.sv
`timescale 1ns / 1ps
// Two-stage multipliers from four 32x32 partial products: Q32.32 product and constant division.
module rbw_qmul (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] p
);

    logic [63:0]  ll_reg, lh_reg, hl_reg, hh_reg;
    logic [63:0]  p_reg;
    logic [127:0] full;
    logic [63:0]  p_next;

    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg <= 64'(a[31:0]) * 64'(b[31:0]);
            lh_reg <= 64'(a[31:0]) * 64'(b[63:32]);
            hl_reg <= 64'(a[63:32]) * 64'(b[31:0]);
            hh_reg <= 64'(a[63:32]) * 64'(b[63:32]);
            p_reg  <= p_next;
        end
    end

    always_comb begin
        full = {hh_reg, 64'd0} + {32'd0, lh_reg, 32'd0} + {32'd0, hl_reg, 32'd0}
             + {64'd0, ll_reg};
        p_next = (full[127:96] != 32'd0) ? rbw_pkg::ALL_ONES : full[95:32];
    end

    assign p = p_reg;

endmodule

module rbw_cdiv #(
    parameter logic [63:0] MAGIC = rbw_pkg::DIV3_MAGIC,
    parameter int          SHIFT = rbw_pkg::DIV3_SHIFT
) (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] a,
    output logic [63:0] q
);

    logic [63:0]  ll_reg, lh_reg, hl_reg, hh_reg;
    logic [63:0]  q_reg;
    logic [127:0] full;
    logic [63:0]  q_next;

    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg <= 64'(a[31:0]) * 64'(MAGIC[31:0]);
            lh_reg <= 64'(a[31:0]) * 64'(MAGIC[63:32]);
            hl_reg <= 64'(a[63:32]) * 64'(MAGIC[31:0]);
            hh_reg <= 64'(a[63:32]) * 64'(MAGIC[63:32]);
            q_reg  <= q_next;
        end
    end

    always_comb begin
        full = {hh_reg, 64'd0} + {32'd0, lh_reg, 32'd0} + {32'd0, hl_reg, 32'd0}
             + {64'd0, ll_reg};
        q_next = full[127:64] >> SHIFT;
    end

    assign q = q_reg;

endmodule

### rtl/rbw_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider of a 128-bit dividend by a 64-bit divisor, with saturation.
module rbw_div (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] hi,
    input  logic [63:0] lo,
    input  logic [63:0] d,
    output logic [63:0] q,
    output logic        sat
);

    localparam int N = rbw_pkg::DIV_STAGES;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] lo;
        logic [63:0] q;
    } div_st_t;

    function automatic div_st_t div_iter(input div_st_t s, input logic [63:0] dv);
        logic [64:0] t;
        div_st_t     r;
        t    = {s.rem, s.lo[63]};
        r.lo = {s.lo[62:0], 1'b0};
        if (t >= {1'b0, dv}) begin
            r.rem = 64'(t - {1'b0, dv});
            r.q   = {s.q[62:0], 1'b1};
        end else begin
            r.rem = t[63:0];
            r.q   = {s.q[62:0], 1'b0};
        end
        return r;
    endfunction

    div_st_t     st_reg  [0:N];
    logic        sat_reg [0:N];
    logic [63:0] d_reg   [0:N-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0]  <= '{rem: hi, lo: lo, q: 64'd0};
            sat_reg[0] <= (d == 64'd0) || (hi >= d);
            d_reg[0]   <= d;
        end
    end

    for (genvar j = 0; j < N; j++) begin : g_stage
        div_st_t st_next;

        always_comb begin
            st_next = st_reg[j];
            for (int k = 0; k < rbw_pkg::DIV_BITS_PER_STAGE; k++) begin
                st_next = div_iter(st_next, d_reg[j]);
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[j+1]  <= st_next;
                sat_reg[j+1] <= sat_reg[j];
            end
        end

        if (j < N - 1) begin : g_d
            always_ff @(posedge aclk) begin
                if (en) begin
                    d_reg[j+1] <= d_reg[j];
                end
            end
        end
    end

    assign q   = sat_reg[N] ? rbw_pkg::ALL_ONES : st_reg[N].q;
    assign sat = sat_reg[N];

endmodule

### rtl/rbw_sqrt.sv
`timescale 1ns / 1ps
// Pipelined digit-by-digit square root of a Q32.32 value.
module rbw_sqrt (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] a,
    output logic [63:0] r
);

    localparam int N = rbw_pkg::SQRT_STAGES;

    typedef struct packed {
        logic [63:0] rad;
        logic [51:0] rem;
        logic [47:0] root;
    } sqrt_st_t;

    function automatic sqrt_st_t sqrt_iter(input sqrt_st_t s);
        logic [51:0] rem2;
        logic [51:0] trial;
        sqrt_st_t    o;
        rem2  = {s.rem[49:0], s.rad[63:62]};
        trial = {2'b00, s.root, 2'b01};
        o.rad = {s.rad[61:0], 2'b00};
        if (rem2 >= trial) begin
            o.rem  = rem2 - trial;
            o.root = {s.root[46:0], 1'b1};
        end else begin
            o.rem  = rem2;
            o.root = {s.root[46:0], 1'b0};
        end
        return o;
    endfunction

    sqrt_st_t st_reg [0:N];

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0] <= '{rad: a, rem: 52'd0, root: 48'd0};
        end
    end

    for (genvar j = 0; j < N; j++) begin : g_stage
        sqrt_st_t st_next;

        always_comb begin
            st_next = st_reg[j];
            for (int k = 0; k < rbw_pkg::SQRT_BITS_PER_STAGE; k++) begin
                st_next = sqrt_iter(st_next);
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[j+1] <= st_next;
            end
        end
    end

    assign r = {16'd0, st_reg[N].root};

endmodule

### rtl/rbw_delay.sv
`timescale 1ns / 1ps
// Shift-register delay line that keeps side data aligned with the arithmetic units.
module rbw_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule
